// ----- sv/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

	// Quaternion registers are always 16 bits, signed, Q1.QUAT_FRAC_BITS.
	localparam int QUAT_REG_WIDTH = 16;

	// Defaults for the top-level parameters.
	localparam int COORD_WIDTH_DEF = 16;
	localparam int QUAT_FRAC_BITS_DEF = 14;

	// Configuration port geometry: four 32-bit registers at byte offsets 4*i.
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_ADDR_WIDTH = 4;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_QUAT_X,
		REG_QUAT_Y,
		REG_QUAT_Z,
		REG_QUAT_W
	} reg_idx_t;

	// The rotation quaternion as held by the register file.
	typedef struct packed {
		logic signed [QUAT_REG_WIDTH-1:0] x;
		logic signed [QUAT_REG_WIDTH-1:0] y;
		logic signed [QUAT_REG_WIDTH-1:0] z;
		logic signed [QUAT_REG_WIDTH-1:0] w;
	} quat_t;

	// Width of the intermediate product t = q * v after rounding: a sum of three
	// coordinate-by-quaternion products, plus the rounding carry, less the fraction.
	function automatic int t_width(int coord_width, int frac_bits);
		return coord_width + QUAT_REG_WIDTH + 3 - frac_bits;
	endfunction

endpackage

// ----- sv/qvr_if.sv -----
`timescale 1ns / 1ps

// Input vector channel.
interface qvr_in_if import qvr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vec_x;
	logic signed [COORD_WIDTH-1:0] vec_y;
	logic signed [COORD_WIDTH-1:0] vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// Rotated vector channel.
interface qvr_out_if import qvr_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rot_x;
	logic signed [COORD_WIDTH-1:0] rot_y;
	logic signed [COORD_WIDTH-1:0] rot_z;

	modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
	modport sink (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

// ----- sv/qvr_cfg_regs.sv -----
`timescale 1ns / 1ps

module qvr_cfg_regs import qvr_pkg::*; #(
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	output quat_t                     quat
);

	// One in Q1.QUAT_FRAC_BITS, truncated to the register width.
	localparam logic [QUAT_REG_WIDTH-1:0] W_RESET =
		QUAT_REG_WIDTH'(64'd1 << QUAT_FRAC_BITS);

	quat_t    quat_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign quat   = quat_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.x <= '0;
			quat_q.y <= '0;
			quat_q.z <= '0;
			quat_q.w <= W_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_QUAT_X: quat_q.x <= pwdata[QUAT_REG_WIDTH-1:0];
				REG_QUAT_Y: quat_q.y <= pwdata[QUAT_REG_WIDTH-1:0];
				REG_QUAT_Z: quat_q.z <= pwdata[QUAT_REG_WIDTH-1:0];
				REG_QUAT_W: quat_q.w <= pwdata[QUAT_REG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read data is the sign-extended register value.
	always_comb begin
		case (idx)
			REG_QUAT_X: prdata = CFG_DATA_WIDTH'(quat_q.x);
			REG_QUAT_Y: prdata = CFG_DATA_WIDTH'(quat_q.y);
			REG_QUAT_Z: prdata = CFG_DATA_WIDTH'(quat_q.z);
			REG_QUAT_W: prdata = CFG_DATA_WIDTH'(quat_q.w);
			default:    prdata = '0;
		endcase
	end

endmodule

// ----- sv/qvr_left.sv -----
`timescale 1ns / 1ps

// Left product t = q * v, with v a pure quaternion. Stage one holds the twelve
// exact products, stage two the four rounded sums.
module qvr_left import qvr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic signed [COORD_WIDTH-1:0] vec_z,
	input  quat_t                         quat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_w,
	output logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_x,
	output logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_y,
	output logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_z
);

	localparam int PW = COORD_WIDTH + QUAT_REG_WIDTH;
	localparam int SW = PW + 2;
	localparam int TW = t_width(COORD_WIDTH, QUAT_FRAC_BITS);
	localparam logic signed [SW:0] HALF = (SW + 1)'(1) <<< (QUAT_FRAC_BITS - 1);

	logic                 valid_s1, valid_s2;
	logic                 ready_s1, ready_s2;
	logic signed [PW-1:0] prod_s1 [12];
	logic signed [SW-1:0] sum_w, sum_x, sum_y, sum_z;
	logic signed [SW:0]   rnd_w, rnd_x, rnd_y, rnd_z;
	logic signed [TW-1:0] t_w_s2, t_x_s2, t_y_s2, t_z_s2;

	// A stage takes new data when it is empty or its contents move on.
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage one: exact products, grouped by the component of t they feed.
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			prod_s1[0]  <= PW'(quat.x) * PW'(vec_x);
			prod_s1[1]  <= PW'(quat.y) * PW'(vec_y);
			prod_s1[2]  <= PW'(quat.z) * PW'(vec_z);
			prod_s1[3]  <= PW'(quat.w) * PW'(vec_x);
			prod_s1[4]  <= PW'(quat.y) * PW'(vec_z);
			prod_s1[5]  <= PW'(quat.z) * PW'(vec_y);
			prod_s1[6]  <= PW'(quat.w) * PW'(vec_y);
			prod_s1[7]  <= PW'(quat.z) * PW'(vec_x);
			prod_s1[8]  <= PW'(quat.x) * PW'(vec_z);
			prod_s1[9]  <= PW'(quat.w) * PW'(vec_z);
			prod_s1[10] <= PW'(quat.x) * PW'(vec_y);
			prod_s1[11] <= PW'(quat.y) * PW'(vec_x);
		end
	end

	// Stage two: signed sums, then round half up and drop the fraction bits.
	always_comb begin
		sum_w = -SW'(prod_s1[0]) - SW'(prod_s1[1]) - SW'(prod_s1[2]);
		sum_x =  SW'(prod_s1[3]) + SW'(prod_s1[4]) - SW'(prod_s1[5]);
		sum_y =  SW'(prod_s1[6]) + SW'(prod_s1[7]) - SW'(prod_s1[8]);
		sum_z =  SW'(prod_s1[9]) + SW'(prod_s1[10]) - SW'(prod_s1[11]);
		rnd_w = (SW + 1)'(sum_w) + HALF;
		rnd_x = (SW + 1)'(sum_x) + HALF;
		rnd_y = (SW + 1)'(sum_y) + HALF;
		rnd_z = (SW + 1)'(sum_z) + HALF;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			t_w_s2 <= rnd_w[SW:QUAT_FRAC_BITS];
			t_x_s2 <= rnd_x[SW:QUAT_FRAC_BITS];
			t_y_s2 <= rnd_y[SW:QUAT_FRAC_BITS];
			t_z_s2 <= rnd_z[SW:QUAT_FRAC_BITS];
		end
	end

	assign out_valid = valid_s2;
	assign t_w = t_w_s2;
	assign t_x = t_x_s2;
	assign t_y = t_y_s2;
	assign t_z = t_z_s2;

	// A stalled stage one keeps its products.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(prod_s1[0]) && $stable(prod_s1[11]))
		else $error("stage one products changed during a stall");

	// Data leaving stage one always lands in stage two.
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("transaction lost between stage one and stage two");

endmodule

// ----- sv/qvr_right.sv -----
`timescale 1ns / 1ps

// Right product r = t * conj(q), vector part only. Stage three holds the twelve
// exact products, stage four the rounded and saturated result.
module qvr_right import qvr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_w,
	input  logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_x,
	input  logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_y,
	input  logic signed [t_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] t_z,
	input  quat_t                         quat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] rot_x,
	output logic signed [COORD_WIDTH-1:0] rot_y,
	output logic signed [COORD_WIDTH-1:0] rot_z
);

	localparam int TW = t_width(COORD_WIDTH, QUAT_FRAC_BITS);
	localparam int PW = TW + QUAT_REG_WIDTH;
	localparam int SW = PW + 2;
	localparam int RW = SW + 1 - QUAT_FRAC_BITS;
	localparam logic signed [SW:0] HALF = (SW + 1)'(1) <<< (QUAT_FRAC_BITS - 1);
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	logic                          valid_s3, valid_s4;
	logic                          ready_s3, ready_s4;
	logic signed [PW-1:0]          prod_s3 [12];
	logic signed [SW-1:0]          sum [3];
	logic signed [SW:0]            rnd [3];
	logic signed [RW-1:0]          res [3];
	logic signed [COORD_WIDTH-1:0] sat [3];
	logic signed [COORD_WIDTH-1:0] rot_s4 [3];

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage three: exact products, four per output component.
	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			prod_s3[0]  <= PW'(t_x) * PW'(quat.w);
			prod_s3[1]  <= PW'(t_w) * PW'(quat.x);
			prod_s3[2]  <= PW'(t_y) * PW'(quat.z);
			prod_s3[3]  <= PW'(t_z) * PW'(quat.y);
			prod_s3[4]  <= PW'(t_y) * PW'(quat.w);
			prod_s3[5]  <= PW'(t_w) * PW'(quat.y);
			prod_s3[6]  <= PW'(t_z) * PW'(quat.x);
			prod_s3[7]  <= PW'(t_x) * PW'(quat.z);
			prod_s3[8]  <= PW'(t_z) * PW'(quat.w);
			prod_s3[9]  <= PW'(t_w) * PW'(quat.z);
			prod_s3[10] <= PW'(t_x) * PW'(quat.y);
			prod_s3[11] <= PW'(t_y) * PW'(quat.x);
		end
	end

	// Stage four: sum, round half up, drop the fraction and clamp to the output range.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = SW'(prod_s3[4*i]) - SW'(prod_s3[4*i+1])
				- SW'(prod_s3[4*i+2]) + SW'(prod_s3[4*i+3]);
			rnd[i] = (SW + 1)'(sum[i]) + HALF;
			res[i] = rnd[i][SW:QUAT_FRAC_BITS];
			if (res[i] > RW'(CMAX)) begin
				sat[i] = CMAX;
			end else if (res[i] < RW'(CMIN)) begin
				sat[i] = CMIN;
			end else begin
				sat[i] = res[i][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			rot_s4[0] <= sat[0];
			rot_s4[1] <= sat[1];
			rot_s4[2] <= sat[2];
		end
	end

	assign out_valid = valid_s4;
	assign rot_x = rot_s4[0];
	assign rot_y = rot_s4[1];
	assign rot_z = rot_s4[2];

	// A stalled stage three keeps its products.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !ready_s4 |=> valid_s3 && $stable(prod_s3[0]) && $stable(prod_s3[11]))
		else $error("stage three products changed during a stall");

	// Data leaving stage three always lands in the output register.
	a_s4_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && ready_s4 |=> valid_s4)
		else $error("transaction lost between stage three and the output register");

endmodule

// ----- sv/quaternion_vector_rotate_unit.sv -----
`timescale 1ns / 1ps

// Quaternion vector rotation unit.
// Vectors arrive on vec_in (valid/ready); each transaction carries vec_x, vec_y
// and vec_z. For every input the unit returns one transaction on rot_out with
// the vector part of q * v * conj(q), rounded and saturated to COORD_WIDTH bits.
// The quaternion q is written over the APB port: quat_x, quat_y, quat_z, quat_w at
// byte offsets 0, 4, 8 and 12, signed Q1.QUAT_FRAC_BITS; writes are expected only
// while no transaction is in flight. Reads return the sign-extended register.
// A vector accepted on vec_in passes through four register stages (two multiply
// stages, each followed by a sum stage) on its way to rot_out. The unit takes
// one vector per cycle unless a stall on rot_out has filled every stage.
// When rot_out stalls, the stages fill up and vec_in drops ready only once no
// stage has room; nothing is lost or repeated. Empty stages close up, so input
// is still taken while a finished result waits.
// Reset clears all stage valid bits and loads the identity quaternion.
module quaternion_vector_rotate_unit import qvr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	qvr_in_if.sink                    vec_in,
	qvr_out_if.source                 rot_out,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0] paddr,
	input  logic [CFG_DATA_WIDTH-1:0] pwdata,
	output logic [CFG_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	localparam int TW = t_width(COORD_WIDTH, QUAT_FRAC_BITS);

	quat_t                quat;
	logic                 mid_valid, mid_ready;
	logic signed [TW-1:0] t_w, t_x, t_y, t_z;

	// Quaternion registers.
	qvr_cfg_regs #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.quat    (quat)
	);

	// First half: t = q * v.
	qvr_left #(
		.COORD_WIDTH   (COORD_WIDTH),
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vec_in.valid),
		.in_ready  (vec_in.ready),
		.vec_x     (vec_in.vec_x),
		.vec_y     (vec_in.vec_y),
		.vec_z     (vec_in.vec_z),
		.quat      (quat),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.t_w       (t_w),
		.t_x       (t_x),
		.t_y       (t_y),
		.t_z       (t_z)
	);

	// Second half: r = t * conj(q), output register included.
	qvr_right #(
		.COORD_WIDTH   (COORD_WIDTH),
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.t_w       (t_w),
		.t_x       (t_x),
		.t_y       (t_y),
		.t_z       (t_z),
		.quat      (quat),
		.out_valid (rot_out.valid),
		.out_ready (rot_out.ready),
		.rot_x     (rot_out.rot_x),
		.rot_y     (rot_out.rot_y),
		.rot_z     (rot_out.rot_z)
	);

endmodule
